### hw/rtl/base64_line_encoder_macros.svh
// Assertion helpers for the base64 line encoder; clk and rst_n are taken from the scope.
`ifndef BASE64_LINE_ENCODER_MACROS_SVH
`define BASE64_LINE_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define B64LE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("b64le assertion failed");
`define B64LE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64le assertion failed");
`else
`define B64LE_ASSERT(lbl, prop)
`define B64LE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/b64le_pkg.sv
package b64le_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] GPL_RESET = 8'd18;
  localparam logic [7:0] CHAR_PAD  = 8'h3d;
  localparam logic [7:0] CHAR_CR   = 8'h0d;
  localparam logic [7:0] CHAR_LF   = 8'h0a;

  localparam logic [2:0] IDX_SX0 = 3'd0;
  localparam logic [2:0] IDX_SX1 = 3'd1;
  localparam logic [2:0] IDX_SX2 = 3'd2;
  localparam logic [2:0] IDX_SX3 = 3'd3;
  localparam logic [2:0] IDX_CR  = 3'd4;
  localparam logic [2:0] IDX_LF  = 3'd5;

  typedef struct packed {
    logic [5:0] sx0;
    logic [5:0] sx1;
    logic [5:0] sx2;
    logic [5:0] sx3;
    logic       pad2;
    logic       pad3;
    logic       crlf;
    logic       last;
  } group_rec_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26)      c = 8'h41 + {2'b00, v};
    else if (v < 6'd52) c = 8'h61 + {2'b00, v} - 8'd26;
    else if (v < 6'd62) c = 8'h30 + {2'b00, v} - 8'd52;
    else if (v == 6'd62) c = 8'h2b;
    else                c = 8'h2f;
    return c;
  endfunction

endpackage

### hw/rtl/b64le_front.sv
module b64le_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  message_end,
  input  logic [7:0]            groups_per_line,
  output logic                  push,
  output b64le_pkg::group_rec_t rec
);

  logic [15:0] held_r, held_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [7:0]  line_r, line_nxt;

  logic [1:0] fill_eff;
  logic       close;
  logic [7:0] b0, b1, b2;
  logic [7:0] line_inc;
  logic       crlf;

  always_comb begin
    fill_eff = fill_r[1] ? 2'd2 : fill_r;
    close    = (fill_eff == 2'd2) || message_end;
    b0 = (fill_eff == 2'd0) ? data_byte : held_r[15:8];
    b1 = (fill_eff == 2'd1) ? data_byte : ((fill_eff == 2'd2) ? held_r[7:0] : 8'h00);
    b2 = (fill_eff == 2'd2) ? data_byte : 8'h00;
    line_inc = (line_r == 8'hff) ? line_r : line_r + 8'd1;
    crlf     = message_end || (line_inc >= groups_per_line);

    rec.sx0  = b0[7:2];
    rec.sx1  = {b0[1:0], b1[7:4]};
    rec.sx2  = {b1[3:0], b2[7:6]};
    rec.sx3  = b2[5:0];
    rec.pad2 = (fill_eff == 2'd0);
    rec.pad3 = (fill_eff != 2'd2);
    rec.crlf = crlf;
    rec.last = message_end;

    push = accept && close;

    held_nxt = held_r;
    fill_nxt = fill_r;
    line_nxt = line_r;
    if (accept) begin
      if (close) begin
        held_nxt = 16'h0000;
        fill_nxt = 2'd0;
        line_nxt = crlf ? 8'h00 : line_inc;
      end else if (fill_eff == 2'd0) begin
        held_nxt = {data_byte, 8'h00};
        fill_nxt = 2'd1;
      end else begin
        held_nxt = {held_r[15:8], data_byte};
        fill_nxt = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 16'h0000;
      fill_r <= 2'd0;
      line_r <= 8'h00;
    end else begin
      held_r <= held_nxt;
      fill_r <= fill_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

### hw/rtl/b64le_queue.sv
module b64le_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  b64le_pkg::group_rec_t push_rec,
  input  logic                  pop,
  output b64le_pkg::group_rec_t head_rec,
  output logic                  empty,
  output logic                  full
);

  b64le_pkg::group_rec_t mem_r [b64le_pkg::QDEPTH];
  logic [b64le_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [b64le_pkg::QCNT_W-1:0] cnt_r;

  localparam logic [b64le_pkg::QPTR_W-1:0] PTR_LAST = b64le_pkg::QPTR_W'(b64le_pkg::QDEPTH - 1);
  localparam logic [b64le_pkg::QPTR_W-1:0] PTR_ONE  = b64le_pkg::QPTR_W'(1);
  localparam logic [b64le_pkg::QCNT_W-1:0] CNT_FULL = b64le_pkg::QCNT_W'(b64le_pkg::QDEPTH);
  localparam logic [b64le_pkg::QCNT_W-1:0] CNT_ONE  = b64le_pkg::QCNT_W'(1);

  logic do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_FULL);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_rec = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PTR_LAST) ? '0 : wr_r + PTR_ONE;
      if (do_pop)  rd_r <= (rd_r == PTR_LAST) ? '0 : rd_r + PTR_ONE;
      if (do_push && !do_pop)      cnt_r <= cnt_r + CNT_ONE;
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_ONE;
    end
  end

endmodule

### hw/rtl/b64le_back.sv
`include "base64_line_encoder_macros.svh"

module b64le_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  b64le_pkg::group_rec_t head_rec,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char,
  output logic                  out_run_last,
  output logic                  out_message_done
);

  logic [2:0] idx_r;
  logic       out_valid_r;
  logic [7:0] char_r;
  logic       run_last_r, done_r;

  logic       load, emit, is_end;
  logic [2:0] end_idx;
  logic [7:0] char_nxt;

  always_comb begin
    load    = !out_valid_r || !out_stall;
    emit    = load && !q_empty;
    end_idx = head_rec.crlf ? b64le_pkg::IDX_LF : b64le_pkg::IDX_SX3;
    is_end  = (idx_r == end_idx);
    q_pop   = emit && is_end;
    case (idx_r)
      b64le_pkg::IDX_SX0: char_nxt = b64le_pkg::b64_char(head_rec.sx0);
      b64le_pkg::IDX_SX1: char_nxt = b64le_pkg::b64_char(head_rec.sx1);
      b64le_pkg::IDX_SX2: char_nxt = head_rec.pad2 ? b64le_pkg::CHAR_PAD
                                                   : b64le_pkg::b64_char(head_rec.sx2);
      b64le_pkg::IDX_SX3: char_nxt = head_rec.pad3 ? b64le_pkg::CHAR_PAD
                                                   : b64le_pkg::b64_char(head_rec.sx3);
      b64le_pkg::IDX_CR:  char_nxt = b64le_pkg::CHAR_CR;
      b64le_pkg::IDX_LF:  char_nxt = b64le_pkg::CHAR_LF;
      default:            char_nxt = b64le_pkg::CHAR_LF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= b64le_pkg::IDX_SX0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (!q_empty) begin
        char_r     <= char_nxt;
        run_last_r <= is_end;
        done_r     <= is_end && head_rec.last;
        idx_r      <= is_end ? b64le_pkg::IDX_SX0 : idx_r + 3'd1;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char         = char_r;
  assign out_run_last     = run_last_r;
  assign out_message_done = done_r;

  `B64LE_ASSERT(a_idx_range, idx_r <= b64le_pkg::IDX_LF)
  `B64LE_ASSERT(a_rec_held, (idx_r == b64le_pkg::IDX_SX0) || !q_empty)
  `B64LE_ASSERT(a_done_closes, !(out_valid_r && done_r) || run_last_r)
  `B64LE_ASSERT_NEXT(a_pop_rewinds, q_pop, idx_r == b64le_pkg::IDX_SX0)

endmodule

### hw/rtl/base64_line_encoder.sv
// Base64 encoder with CR LF line breaks. Bytes enter one per transaction; each third byte,
// or a byte flagged message_end, closes a group that yields four characters ('=' padding a
// short final group), followed by CR LF once groups_per_line groups sit on the line or the
// message ends. The output side emits one character per cycle while out_stall is low and a
// group is queued, so a group yields four or six characters, held in the single-character output
// register. A two-entry group queue separates input from output; input stalls only
// while that queue is full. groups_per_line (reset 18) is at address 0 and should be
// changed only while the encoder is idle.
module base64_line_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_message_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_run_last,
  output logic        out_message_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] gpl_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'h0 : {24'h0, gpl_r};

  always_ff @(posedge clk) begin
    if (!rst_n) gpl_r <= b64le_pkg::GPL_RESET;
    else if (cfg_wr) gpl_r <= pwdata[7:0];
  end

  logic                  q_full, q_empty, push, pop, accept;
  b64le_pkg::group_rec_t push_rec, head_rec;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  b64le_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .data_byte       (in_data_byte),
    .message_end     (in_message_end),
    .groups_per_line (gpl_r),
    .push            (push),
    .rec             (push_rec)
  );

  b64le_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .empty    (q_empty),
    .full     (q_full)
  );

  b64le_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_rec         (head_rec),
    .q_empty          (q_empty),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_run_last     (out_run_last),
    .out_message_done (out_message_done)
  );

endmodule
